// ===== sv/cps_pkg.sv =====
// shared types and constants for the charger plug sequencer
`timescale 1ns / 1ps

package cps_pkg;

    localparam int PILOT_W   = 12;
    localparam int VOLT_W    = 16;
    localparam int CURR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESUME_HYST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLUGGED_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_LIMIT  = 3'd4;

    localparam logic [VOLT_W-1:0]  RST_MAX_VOLTAGE   = 16'd4000;
    localparam logic [CURR_W-1:0]  RST_MAX_CURRENT   = 8'd10;
    localparam logic [VOLT_W-1:0]  RST_RESUME_HYST   = 16'd10;
    localparam logic [PILOT_W-1:0] RST_PLUGGED_LIMIT = 12'h900;
    localparam logic [PILOT_W-1:0] RST_BUTTON_LIMIT  = 12'hC80;

    typedef enum logic [2:0] {
        PH_DISCONNECTED = 3'd0,
        PH_BLOCKED      = 3'd1,
        PH_CONNECTED    = 3'd2,
        PH_CHARGING     = 3'd3,
        PH_CHARGED      = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        PLUG_EMPTY   = 2'd0,
        PLUG_BUTTON  = 2'd1,
        PLUG_PLUGGED = 2'd2
    } t_plug;

    typedef struct packed {
        logic [VOLT_W-1:0]  max_voltage;
        logic [CURR_W-1:0]  max_current;
        logic [VOLT_W-1:0]  resume_hyst;
        logic [PILOT_W-1:0] plugged_limit;
        logic [PILOT_W-1:0] button_limit;
    } t_cfg;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_voltage_max;
        logic [VOLT_W-1:0] cutoff_voltage;
    } t_volts;

    typedef struct packed {
        logic              relay;
        t_plug             plug;
        t_phase            phase;
        logic [VOLT_W-1:0] voltage;
        logic [CURR_W-1:0] current;
        logic              request;
    } t_state;

endpackage

// ===== sv/charger_plug_sequencer.sv =====
// top level: input register, state update, result register
// an input goes to the input register, its result to the state register
// throughput: one item per cycle, limited only by the master-side tready
// the state register doubles as the result register and advances only when
// the previous result has been taken
// reset (synchronous, active low) clears both stages, the charger state and
// loads the configuration defaults
`timescale 1ns / 1ps

module charger_plug_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pilot_sample, cell_voltage_max, cutoff_voltage
    input  logic [cps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // relay_closed, plug_state, charge_state, voltage_setpoint,
    // current_setpoint, charge_request
    output logic [cps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cps_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import cps_pkg::*;

    t_cfg               w_cfg;
    logic               r_in_valid;
    logic [PILOT_W-1:0] r_pilot;
    t_volts             r_volts;
    logic               r_out_valid;
    t_state             r_state;
    t_state             n_state;
    t_plug              w_plug;
    logic               w_advance;

    cps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cps_classify u_classify (
        .i_pilot         (r_pilot),
        .i_plugged_limit (w_cfg.plugged_limit),
        .i_button_limit  (w_cfg.button_limit),
        .o_plug          (w_plug)
    );

    cps_step u_step (
        .i_plug  (w_plug),
        .i_volts (r_volts),
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .o_state (n_state)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_pilot                  <= s_axis_tdata[11:0];
            r_volts.cell_voltage_max <= s_axis_tdata[27:12];
            r_volts.cutoff_voltage   <= s_axis_tdata[43:28];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_state.relay   <= 1'b0;
            r_state.plug    <= PLUG_EMPTY;
            r_state.phase   <= PH_DISCONNECTED;
            r_state.voltage <= '0;
            r_state.current <= '0;
            r_state.request <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_state.request, r_state.current, r_state.voltage,
                            r_state.phase, r_state.plug, r_state.relay};

    a_relay_matches_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.relay == r_state.request)
        else $error("relay and charge request disagree");

    a_charging_needs_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_CHARGING || r_state.phase == PH_CHARGED) |-> r_state.relay)
        else $error("charging phase with relay open");

    a_current_only_charging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.current != '0) |-> (r_state.phase == PH_CHARGING))
        else $error("current setpoint outside charging");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are full");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_state))
        else $error("state changed while result waits");

endmodule

// ===== sv/cps_cfg_regs.sv =====
// configuration register file
`timescale 1ns / 1ps

module cps_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cps_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output cps_pkg::t_cfg                    o_cfg
);
    import cps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_VOLTAGE:   n_cfg.max_voltage   = i_cfg_data;
                REG_MAX_CURRENT:   n_cfg.max_current   = i_cfg_data[CURR_W-1:0];
                REG_RESUME_HYST:   n_cfg.resume_hyst   = i_cfg_data;
                REG_PLUGGED_LIMIT: n_cfg.plugged_limit = i_cfg_data[PILOT_W-1:0];
                REG_BUTTON_LIMIT:  n_cfg.button_limit  = i_cfg_data[PILOT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_voltage   <= RST_MAX_VOLTAGE;
            r_cfg.max_current   <= RST_MAX_CURRENT;
            r_cfg.resume_hyst   <= RST_RESUME_HYST;
            r_cfg.plugged_limit <= RST_PLUGGED_LIMIT;
            r_cfg.button_limit  <= RST_BUTTON_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/cps_classify.sv =====
// proximity pilot classifier
`timescale 1ns / 1ps

module cps_classify (
    input  logic [cps_pkg::PILOT_W-1:0] i_pilot,
    input  logic [cps_pkg::PILOT_W-1:0] i_plugged_limit,
    input  logic [cps_pkg::PILOT_W-1:0] i_button_limit,
    output cps_pkg::t_plug              o_plug
);
    import cps_pkg::*;

    always_comb begin
        if (i_pilot <= i_button_limit && i_pilot > i_plugged_limit) begin
            o_plug = PLUG_BUTTON;
        end else if (i_pilot <= i_plugged_limit) begin
            o_plug = PLUG_PLUGGED;
        end else begin
            o_plug = PLUG_EMPTY;
        end
    end

endmodule

// ===== sv/cps_step.sv =====
// next charger state from plug class, voltages and present state
`timescale 1ns / 1ps

module cps_step (
    input  cps_pkg::t_plug  i_plug,
    input  cps_pkg::t_volts i_volts,
    input  cps_pkg::t_cfg   i_cfg,
    input  cps_pkg::t_state i_state,
    output cps_pkg::t_state o_state
);
    import cps_pkg::*;

    logic [VOLT_W:0] w_resume_sum;
    logic            w_resume;
    logic            w_cutoff;

    // cell < cutoff - hyst (signed) rewritten as cell + hyst < cutoff
    assign w_resume_sum = {1'b0, i_volts.cell_voltage_max} + {1'b0, i_cfg.resume_hyst};
    assign w_resume     = w_resume_sum < {1'b0, i_volts.cutoff_voltage};
    assign w_cutoff     = i_volts.cell_voltage_max >= i_volts.cutoff_voltage;

    always_comb begin
        o_state = i_state;
        case (i_plug)
            PLUG_BUTTON: begin
                o_state.plug    = PLUG_BUTTON;
                o_state.current = '0;
                o_state.voltage = '0;
                o_state.phase   = PH_BLOCKED;
            end
            PLUG_PLUGGED: begin
                o_state.plug = PLUG_PLUGGED;
                case (i_state.phase)
                    PH_DISCONNECTED, PH_BLOCKED, PH_CONNECTED: begin
                        o_state.relay   = 1'b1;
                        o_state.voltage = i_cfg.max_voltage;
                        o_state.request = 1'b1;
                        o_state.phase   = PH_CHARGING;
                    end
                    PH_CHARGING: begin
                        if (w_cutoff) begin
                            o_state.phase   = PH_CHARGED;
                            o_state.voltage = '0;
                            o_state.current = '0;
                        end else if (i_state.current < i_cfg.max_current) begin
                            o_state.current = i_state.current + 1'b1;
                        end
                    end
                    PH_CHARGED: begin
                        if (w_resume) begin
                            o_state.phase = PH_CHARGING;
                        end
                    end
                    default: o_state = i_state;
                endcase
            end
            default: begin
                o_state.relay   = 1'b0;
                o_state.plug    = PLUG_EMPTY;
                o_state.current = '0;
                o_state.voltage = '0;
                o_state.request = 1'b0;
                o_state.phase   = PH_DISCONNECTED;
            end
        endcase
    end

endmodule
